// ----- hdl/prph_pkg.sv -----
package prph_pkg;

    // Histogram geometry
    localparam int PHASE_BINS  = 360;
    localparam int LEVEL_LIMIT = 60;
    localparam int COUNT_WIDTH = 16;
    localparam int LEVEL_BINS  = 2 * LEVEL_LIMIT + 1;
    localparam int CELLS       = PHASE_BINS * LEVEL_BINS;
    localparam int CELL_AW     = $clog2(CELLS);
    localparam int COL_AW      = $clog2(LEVEL_BINS);
    localparam int PH_IDX_W    = $clog2(PHASE_BINS);

    // Field widths
    localparam int PHASE_W   = 21;
    localparam int AMP_W     = 16;
    localparam int SCALE_W   = 24;
    localparam int ZOFF_W    = 16;
    localparam int MODE_W    = 2;
    localparam int LEVEL_W   = 9;
    localparam int CELL_OW   = 16;
    localparam int TOTAL_W   = 25;
    localparam int CENT_W    = AMP_W + 2;
    localparam int MAG_W     = 24;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 72;

    // Phase product and reciprocal constants
    localparam int PX_W   = PHASE_W + $clog2(PHASE_BINS + 1);
    localparam int DIV_50 = 2000000;
    localparam int DIV_60 = 1666667;
    localparam logic [31:0] RECIP_50 = 32'((64'd1 << PX_W) / 64'(DIV_50));
    localparam logic [31:0] RECIP_60 = 32'((64'd1 << PX_W) / 64'(DIV_60));
    localparam int CENTRE = 32768;

    // Reset values of the registers
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // Register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_ZOFF  = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    // Line frequency modes
    localparam logic [MODE_W-1:0] MODE_50HZ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_60HZ = 2'd1;

    // Opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Level threshold table: entry L is the smallest m with m^20 >= 10^L
    localparam int DB_POWER = 20;
    localparam int LVL_W    = 8;
    localparam int LVL_N    = 2 ** LVL_W;
    localparam int THR_W    = MAG_W + 1;
    localparam int BIG_W    = DB_POWER * THR_W + 8;
    localparam logic [THR_W-1:0] THR_TOP = THR_W'(1) << MAG_W;

    typedef logic [LVL_N-1:0][THR_W-1:0] t_thr_tab;

    function automatic t_thr_tab build_thr();
        t_thr_tab          tab;
        logic [BIG_W-1:0]  p10;
        logic [BIG_W-1:0]  pw;
        logic [THR_W-1:0]  lo;
        logic [THR_W-1:0]  hi;
        logic [THR_W-1:0]  mid;
        logic [THR_W:0]    sum;
        logic              beyond;
        tab    = '0;
        p10    = BIG_W'(1);
        lo     = '0;
        beyond = 1'b0;
        for (int l = 0; l < LVL_N; l++) begin
            if (beyond) begin
                tab[l] = THR_TOP;
            end else begin
                hi = THR_TOP;
                for (int s = 0; s <= THR_W; s++) begin
                    if (lo < hi) begin
                        sum = {1'b0, lo} + {1'b0, hi};
                        mid = sum[THR_W:1];
                        pw  = BIG_W'(1);
                        for (int k = 0; k < DB_POWER; k++) begin
                            pw = pw * BIG_W'(mid);
                        end
                        if (pw >= p10) begin
                            hi = mid;
                        end else begin
                            lo = mid + THR_W'(1);
                        end
                    end
                end
                tab[l] = lo;
                if (lo == THR_TOP) begin
                    beyond = 1'b1;
                end else begin
                    p10 = p10 * BIG_W'(10);
                end
            end
        end
        return tab;
    endfunction

    localparam t_thr_tab THR_TAB = build_thr();

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_PHMUL,
        ST_RECIP,
        ST_BACK,
        ST_FIX,
        ST_LOG,
        ST_READ,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic done;
        logic [LVL_W-1:0] level;
    } t_db_res;

    typedef struct packed {
        logic rd;
        logic clr;
    } t_store_req;

    typedef struct packed {
        logic busy;
        logic upd;
    } t_store_sts;

endpackage

// ----- hdl/prph_mac.sv -----
module prph_mac (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // Registered multiply-add shared by the scale, phase, reciprocal, back-multiply and map-address steps
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b) + 64'(i_c);
    end

    assign o_p = r_p;

endmodule

// ----- hdl/prph_dbsearch.sv -----
module prph_dbsearch (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [prph_pkg::MAG_W-1:0]   i_mag,
    output prph_pkg::t_db_res            o_res
);
    import prph_pkg::*;

    logic [MAG_W-1:0] r_m;
    logic [LVL_W-1:0] r_lvl;
    logic [2:0]       r_bit;
    logic             r_busy;
    logic             r_done;
    logic [LVL_W-1:0] w_cand;
    logic             w_take;

    // Try one more level bit against the threshold table
    assign w_cand = r_lvl | (LVL_W'(1) << r_bit);
    assign w_take = (THR_TAB[w_cand] <= {1'b0, r_m});

    // Control: eight steps, most significant level bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_bit == 3'd0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // Datapath: hold the magnitude, build the level bit by bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_mag;
            r_lvl <= '0;
            r_bit <= 3'(LVL_W - 1);
        end else if (r_busy) begin
            if (w_take) begin
                r_lvl <= w_cand;
            end
            r_bit <= r_bit - 3'd1;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.level = r_lvl;

endmodule

// ----- hdl/prph_store.sv -----
module prph_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prph_pkg::t_store_req          i_req,
    input  logic [prph_pkg::CELL_AW-1:0]  i_idx,
    input  logic [prph_pkg::COL_AW-1:0]   i_col,
    output prph_pkg::t_store_sts          o_sts,
    output logic [prph_pkg::COUNT_WIDTH-1:0] o_cell,
    output logic [prph_pkg::TOTAL_W-1:0]  o_total
);
    import prph_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CELL_MAX  = '1;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;

    logic [COUNT_WIDTH-1:0] cells  [CELLS];
    logic [TOTAL_W-1:0]     totals [LEVEL_BINS];

    logic                   r_clr_busy;
    logic [CELL_AW-1:0]     r_clr_cnt;
    logic                   r_upd;
    logic [CELL_AW-1:0]     r_idx;
    logic [COL_AW-1:0]      r_col;
    logic [COUNT_WIDTH-1:0] r_cell_q;
    logic [TOTAL_W-1:0]     r_tot_q;

    logic                   w_cell_full;
    logic [COUNT_WIDTH-1:0] w_cell_new;
    logic [TOTAL_W-1:0]     w_tot_new;
    logic                   w_cwe;
    logic [CELL_AW-1:0]     w_caddr;
    logic [COUNT_WIDTH-1:0] w_cdata;
    logic                   w_twe;
    logic [COL_AW-1:0]      w_taddr;
    logic [TOTAL_W-1:0]     w_tdata;

    // Saturating increment of the cell; the column follows only a real increment
    assign w_cell_full = (r_cell_q == CELL_MAX);
    assign w_cell_new  = w_cell_full ? r_cell_q : r_cell_q + COUNT_WIDTH'(1);
    assign w_tot_new   = (!w_cell_full && (r_tot_q != TOTAL_MAX)) ?
                         r_tot_q + TOTAL_W'(1) : r_tot_q;

    // Write port select: clearing sweep or update
    always_comb begin
        w_cwe   = r_clr_busy || r_upd;
        w_caddr = r_clr_busy ? r_clr_cnt : r_idx;
        w_cdata = r_clr_busy ? '0 : w_cell_new;
        w_twe   = (r_clr_busy && (r_clr_cnt < CELL_AW'(LEVEL_BINS))) || r_upd;
        w_taddr = r_clr_busy ? r_clr_cnt[COL_AW-1:0] : r_col;
        w_tdata = r_clr_busy ? '0 : w_tot_new;
    end

    // Clearing sweep, started by reset or by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (i_req.clr) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == CELL_AW'(CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + CELL_AW'(1);
        end
    end

    // Update happens in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0;
        end else begin
            r_upd <= i_req.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_idx <= i_idx;
            r_col <= i_col;
        end
    end

    // Count map memory
    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            cells[w_caddr] <= w_cdata;
        end
        if (i_req.rd) begin
            r_cell_q <= cells[i_idx];
        end
    end

    // Column total memory
    always_ff @(posedge i_clk) begin
        if (w_twe) begin
            totals[w_taddr] <= w_tdata;
        end
        if (i_req.rd) begin
            r_tot_q <= totals[i_col];
        end
    end

    assign o_sts.busy = r_clr_busy;
    assign o_sts.upd  = r_upd;
    assign o_cell     = w_cell_new;
    assign o_total    = w_tot_new;

endmodule

// ----- hdl/phase_resolved_pulse_histogram_unit.sv -----
// Phase-resolved pulse histogram. Each record item (tuser 0) carries a phase
// count and a raw amplitude; the block removes the 0x8000 centre and the zero
// offset, applies the Q8.16 scale, finds the signed truncated dB level
// exactly, converts the phase for 50 Hz, 60 Hz or raw use, and when the pulse
// lands in the 360 x 121 map increments the saturating cell and its level
// column total, returning one result item per input item. A record item
// waits in the block for the eight-step level search against the threshold
// table, which runs after the scale multiply; the other steps share one
// registered 32 x 32 multiply-add unit. A clear item (tuser 1) zeroes both
// stores in a sweep over all 43560 cells, one cell a cycle, and then returns
// its result. The same sweep runs after reset; input items are held off
// until it ends, while register writes are taken at once.
module phase_resolved_pulse_histogram_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: phase_count[20:0], amplitude_raw[36:21], zero[39:37]
    input  logic [prph_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode[0]
    input  logic [0:0]  s_axis_tuser,
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: level_db[8:0], phase_degree[29:9], in_map[30], cell_count[46:31],
    //        column_total[71:47]
    output logic [prph_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: clear_done[0]
    output logic [0:0]  m_axis_tuser
);
    import prph_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [SCALE_W-1:0] r_scale;
    logic [ZOFF_W-1:0]  r_zoff;
    logic [MODE_W-1:0]  r_mode;

    // Item and work registers
    logic                 r_opc;
    logic [PHASE_W-1:0]   r_phase;
    logic [AMP_W-1:0]     r_amp;
    logic                 r_neg;
    logic [PX_W-1:0]      r_x;
    logic [PHASE_W-1:0]   r_q;
    logic [PHASE_W-1:0]   r_ph;
    logic [COL_AW-1:0]    r_col;

    // Result registers
    logic [LEVEL_W-1:0]   r_res_level;
    logic                 r_res_hit;
    logic [CELL_OW-1:0]   r_res_cell;
    logic [TOTAL_W-1:0]   r_res_total;
    logic                 r_res_clr;

    // Output register
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_level;
    logic [PHASE_W-1:0]   r_out_ph;
    logic                 r_out_hit;
    logic [CELL_OW-1:0]   r_out_cell;
    logic [TOTAL_W-1:0]   r_out_total;
    logic                 r_out_clr;

    // Shared unit and sub-block links
    logic [31:0]          w_mac_a;
    logic [31:0]          w_mac_b;
    logic [31:0]          w_mac_c;
    logic [63:0]          w_prod;
    logic                 w_db_start;
    t_db_res              w_db;
    t_store_req           w_st_req;
    t_store_sts           w_st_sts;
    logic [COUNT_WIDTH-1:0] w_st_cell;
    logic [TOTAL_W-1:0]   w_st_total;

    // Combinational datapath
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_out_load;
    logic signed [CENT_W-1:0] w_centred;
    logic [AMP_W-1:0]     w_mag;
    logic [PX_W-1:0]      w_x;
    logic [PHASE_W-1:0]   w_q0;
    logic [31:0]          w_div;
    logic [PX_W-1:0]      w_rem;
    logic                 w_raw;
    logic                 w_hit;
    logic [COL_AW-1:0]    w_col;
    logic [LEVEL_W-1:0]   w_level;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // Centre, offset and magnitude
    assign w_centred = $signed({2'b00, r_amp}) - $signed(CENT_W'(CENTRE))
                       - CENT_W'($signed(r_zoff));
    assign w_mag     = w_centred[CENT_W-1] ? AMP_W'(-w_centred) : AMP_W'(w_centred);

    // Phase division by reciprocal with one correction step
    assign w_x   = w_prod[PX_W-1:0];
    assign w_q0  = w_prod[PX_W +: PHASE_W];
    assign w_div = (r_mode == MODE_60HZ) ? 32'(DIV_60) : 32'(DIV_50);
    assign w_rem = r_x - w_prod[PX_W-1:0];
    assign w_raw = (r_mode != MODE_50HZ) && (r_mode != MODE_60HZ);

    // Map hit, column and signed level
    assign w_hit   = (r_ph < PHASE_W'(PHASE_BINS)) && (w_db.level <= LVL_W'(LEVEL_LIMIT));
    assign w_col   = r_neg ? COL_AW'(LEVEL_LIMIT) - COL_AW'(w_db.level)
                           : COL_AW'(LEVEL_LIMIT) + COL_AW'(w_db.level);
    assign w_level = r_neg ? LEVEL_W'(-{1'b0, w_db.level}) : LEVEL_W'({1'b0, w_db.level});

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit controls
    always_comb begin
        n_state    = r_state;
        w_mac_a    = '0;
        w_mac_b    = '0;
        w_mac_c    = '0;
        w_db_start = 1'b0;
        w_st_req   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                if (!w_st_sts.busy) begin
                    n_state = r_opc ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[0] == OP_CLEAR) begin
                        w_st_req.clr = 1'b1;
                        n_state      = ST_CLEAR;
                    end else begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                w_mac_a = 32'(w_mag);
                w_mac_b = 32'(r_scale);
                n_state = ST_PHMUL;
            end
            ST_PHMUL: begin
                w_db_start = 1'b1;
                w_mac_a    = 32'(r_phase);
                w_mac_b    = 32'(PHASE_BINS);
                n_state    = ST_RECIP;
            end
            ST_RECIP: begin
                if (w_raw) begin
                    n_state = ST_LOG;
                end else begin
                    w_mac_a = 32'(w_x);
                    w_mac_b = (r_mode == MODE_60HZ) ? RECIP_60 : RECIP_50;
                    n_state = ST_BACK;
                end
            end
            ST_BACK: begin
                w_mac_a = 32'(w_q0);
                w_mac_b = w_div;
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_state = ST_LOG;
            end
            ST_LOG: begin
                if (w_db.done) begin
                    if (w_hit) begin
                        w_mac_a = 32'(r_ph[PH_IDX_W-1:0]);
                        w_mac_b = 32'(LEVEL_BINS);
                        w_mac_c = 32'(w_col);
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_READ: begin
                w_st_req.rd = 1'b1;
                n_state     = ST_UPD;
            end
            ST_UPD: begin
                if (w_st_sts.upd) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_zoff  <= '0;
            r_mode  <= MODE_50HZ;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                REG_ZOFF:  r_zoff  <= pwdata[ZOFF_W-1:0];
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_SCALE: prdata = 32'(r_scale);
            REG_ZOFF:  prdata = 32'(r_zoff);
            REG_MODE:  prdata = 32'(r_mode);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Capture the item; the sweep after reset returns no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc <= OP_RECORD;
        end else if (w_accept) begin
            r_opc   <= s_axis_tuser[0];
            r_phase <= s_axis_tdata[PHASE_W-1:0];
            r_amp   <= s_axis_tdata[PHASE_W +: AMP_W];
        end
    end

    // Work and result registers, advanced by state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CLEAR: begin
                if (!w_st_sts.busy && r_opc) begin
                    r_ph        <= '0;
                    r_res_level <= '0;
                    r_res_hit   <= 1'b0;
                    r_res_cell  <= '0;
                    r_res_total <= '0;
                    r_res_clr   <= 1'b1;
                end
            end
            ST_SCALE: begin
                r_neg <= w_centred[CENT_W-1];
            end
            ST_RECIP: begin
                r_x <= w_x;
                if (w_raw) begin
                    r_ph <= r_phase;
                end
            end
            ST_BACK: begin
                r_q <= w_q0;
            end
            ST_FIX: begin
                r_ph <= (w_rem >= PX_W'(w_div)) ? r_q + PHASE_W'(1) : r_q;
            end
            ST_LOG: begin
                if (w_db.done) begin
                    r_col       <= w_col;
                    r_res_level <= w_level;
                    r_res_hit   <= w_hit;
                    r_res_cell  <= '0;
                    r_res_total <= '0;
                    r_res_clr   <= 1'b0;
                end
            end
            ST_UPD: begin
                if (w_st_sts.upd) begin
                    r_res_cell  <= CELL_OW'(w_st_cell);
                    r_res_total <= w_st_total;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_level <= r_res_level;
            r_out_ph    <= r_ph;
            r_out_hit   <= r_res_hit;
            r_out_cell  <= r_res_cell;
            r_out_total <= r_res_total;
            r_out_clr   <= r_res_clr;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_total, r_out_cell, r_out_hit, r_out_ph, r_out_level};
    assign m_axis_tuser  = r_out_clr;

    prph_mac u_mac (
        .i_clk (i_clk),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .i_c   (w_mac_c),
        .o_p   (w_prod)
    );

    prph_dbsearch u_dbsearch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_db_start),
        .i_mag   (w_prod[16 +: MAG_W]),
        .o_res   (w_db)
    );

    prph_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_st_req),
        .i_idx   (w_prod[CELL_AW-1:0]),
        .i_col   (r_col),
        .o_sts   (w_st_sts),
        .o_cell  (w_st_cell),
        .o_total (w_st_total)
    );

    // No item enters while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_st_sts.busy)
        else $error("item accepted during clearing sweep");

    // The map address built by the shared unit stays inside the map
    a_addr_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (w_prod < 64'(CELLS)))
        else $error("count map address out of range");

    // A clear result carries no hit and no counts
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clr) |-> (!r_out_hit && (r_out_cell == '0)
                                        && (r_out_total == '0)))
        else $error("clear result carries map data");

    // A hit result always reports a nonzero column total
    a_hit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> (r_out_total != '0))
        else $error("hit result with empty column total");

endmodule

// ----- dv/phase_resolved_pulse_histogram_checker.sv -----
module phase_resolved_pulse_histogram_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register bus, watched for writes
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [3:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    // Input item channel
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    input  logic [prph_pkg::IN_DATA_W-1:0]  i_in_tdata,
    input  logic [0:0]            i_in_tuser,
    // Result item channel
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    input  logic [prph_pkg::OUT_DATA_W-1:0] i_out_tdata,
    input  logic [0:0]            i_out_tuser,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import prph_pkg::*;

    // Result fields, highest bits first so that {tuser, tdata} maps onto them
    typedef struct packed {
        logic                      clear_done;
        logic [TOTAL_W-1:0]        column_total;
        logic [CELL_OW-1:0]        cell_count;
        logic                      in_map;
        logic [PHASE_W-1:0]        phase_degree;
        logic signed [LEVEL_W-1:0] level_db;
    } t_pulse_report;

    t_pulse_report pending_reports[$];
    t_pulse_report oldest;
    t_pulse_report observed;

    // Register copies and histogram stores
    logic [SCALE_W-1:0]        gain;
    logic signed [ZOFF_W-1:0]  offset;
    logic [MODE_W-1:0]         freq_mode;
    logic [COUNT_WIDTH-1:0]    map_cells [CELLS];
    logic [TOTAL_W-1:0]        column_sums [LEVEL_BINS];

    // Largest L with 10^L <= m^20
    function automatic int unsigned decibel_level(input logic [MAG_W-1:0] m);
        logic [511:0] m_pow;
        logic [511:0] decade;
        int unsigned  lvl;
        m_pow = 512'd1;
        for (int k = 0; k < DB_POWER; k++) begin
            m_pow = m_pow * 512'(m);
        end
        decade = 512'd10;
        lvl    = 0;
        while (decade <= m_pow) begin
            decade = decade * 512'd10;
            lvl++;
        end
        return lvl;
    endfunction

    // Work out the result of one item and advance the stores
    function automatic t_pulse_report predict_pulse_report(input logic op,
                                                           input logic [PHASE_W-1:0] pc,
                                                           input logic [AMP_W-1:0] amp);
        t_pulse_report     r;
        int                centred;
        int                mag_abs;
        longint unsigned   scaled;
        int unsigned       lvl_mag;
        int                lvl;
        longint unsigned   ph;
        int                col;
        int                idx;
        r = '0;
        if (op == OP_CLEAR) begin
            foreach (map_cells[i]) map_cells[i] = '0;
            foreach (column_sums[i]) column_sums[i] = '0;
            r.clear_done = 1'b1;
            return r;
        end
        centred = int'(amp) - CENTRE - int'(offset);
        mag_abs = (centred < 0) ? -centred : centred;
        scaled  = (64'(mag_abs) * 64'(gain)) >> 16;
        lvl_mag = (scaled >= 1) ? decibel_level(MAG_W'(scaled)) : 0;
        lvl     = (centred < 0) ? -int'(lvl_mag) : int'(lvl_mag);
        case (freq_mode)
            MODE_50HZ: ph = 64'(pc) * PHASE_BINS / DIV_50;
            MODE_60HZ: ph = 64'(pc) * PHASE_BINS / DIV_60;
            default:   ph = 64'(pc);
        endcase
        if (ph < PHASE_BINS && lvl_mag <= LEVEL_LIMIT) begin
            col = lvl + LEVEL_LIMIT;
            idx = int'(ph) * LEVEL_BINS + col;
            // Saturated cell holds, and so does its column total
            if (map_cells[idx] != '1) begin
                map_cells[idx] = map_cells[idx] + 1'b1;
                if (column_sums[col] != '1) begin
                    column_sums[col] = column_sums[col] + 1'b1;
                end
            end
            r.in_map       = 1'b1;
            r.cell_count   = CELL_OW'(map_cells[idx]);
            r.column_total = column_sums[col];
        end
        r.level_db     = LEVEL_W'(lvl);
        r.phase_degree = PHASE_W'(ph);
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Track register writes, compare results, queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain      = SCALE_RESET;
            offset    = '0;
            freq_mode = MODE_50HZ;
            foreach (map_cells[i]) map_cells[i] = '0;
            foreach (column_sums[i]) column_sums[i] = '0;
            pending_reports.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_hits       = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_SCALE: gain      = i_pwdata[SCALE_W-1:0];
                    REG_ZOFF:  offset    = i_pwdata[ZOFF_W-1:0];
                    REG_MODE:  freq_mode = i_pwdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            // A result at this edge always belongs to an earlier item
            if (i_out_tvalid && i_out_tready) begin
                observed = {i_out_tuser, i_out_tdata};
                if (pending_reports.size() == 0) begin
                    $error("result item with no prediction waiting");
                    o_fail_count++;
                end else begin
                    oldest = pending_reports.pop_front();
                    check_field("level_db", longint'(oldest.level_db),
                                longint'(observed.level_db));
                    check_field("phase_degree", oldest.phase_degree, observed.phase_degree);
                    check_field("in_map", oldest.in_map, observed.in_map);
                    check_field("cell_count", oldest.cell_count, observed.cell_count);
                    check_field("column_total", oldest.column_total, observed.column_total);
                    check_field("clear_done", oldest.clear_done, observed.clear_done);
                    o_checked++;
                    if (observed.in_map) o_hits++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                pending_reports.push_back(predict_pulse_report(i_in_tuser[0],
                                                               i_in_tdata[PHASE_W-1:0],
                                                               i_in_tdata[PHASE_W+:AMP_W]));
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

// ----- dv/tb_phase_resolved_pulse_histogram_unit.sv -----
module tb_phase_resolved_pulse_histogram_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import prph_pkg::*;

    localparam int CYCLE_LIMIT        = 1500000;
    localparam int N_SETTINGS         = 8;
    localparam int RANDOM_PER_SETTING = 117;
    localparam int MAX_RANDOM_CLEARS  = 4;
    localparam int PHASE_COUNT_MAX    = 2097151;
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int hits;

    // Stimulus bookkeeping
    bit                 calm = 1'b0;
    int                 sent_items = 0;
    int                 sent_clears = 0;
    int                 random_clears = 0;
    int                 settings_used = 0;
    int                 cur_zoff = 0;
    logic [MODE_W-1:0]  cur_mode = MODE_50HZ;

    always #5ns i_clk = ~i_clk;

    phase_resolved_pulse_histogram_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    phase_resolved_pulse_histogram_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    // Setup cycle, access cycle, then an idle cycle; called at a falling edge
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one item after a random gap and hold it until taken
    task automatic send_pulse(input logic op, input logic [PHASE_W-1:0] pc,
                              input logic [AMP_W-1:0] amp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, amp, pc};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_items++;
        if (op == OP_CLEAR) sent_clears++;
    endtask

    // Drain, then load a new register setting while the block is idle
    task automatic apply_setting(input logic [SCALE_W-1:0] scale, input int zoff,
                                 input logic [MODE_W-1:0] mode);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        apb_write(REG_SCALE, 32'(scale));
        apb_write(REG_ZOFF, 32'(zoff));
        apb_write(REG_MODE, 32'(mode));
        cur_zoff = zoff;
        cur_mode = mode;
        settings_used++;
    endtask

    // Mostly pulses that land in the map, with hot cells, extremes and noise
    task automatic random_pulse();
        int                 pick;
        int                 span;
        int                 a;
        logic               op;
        logic [PHASE_W-1:0] pc;
        logic [AMP_W-1:0]   amp;
        op = OP_RECORD;
        if (random_clears < MAX_RANDOM_CLEARS && $urandom_range(0, 299) == 0) begin
            op = OP_CLEAR;
            random_clears++;
        end
        case (cur_mode)
            MODE_50HZ: span = DIV_50 - 1;
            MODE_60HZ: span = DIV_60 - 1;
            default:   span = PHASE_BINS - 1;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            // Hammer a handful of cells
            pc  = PHASE_W'($urandom_range(0, 3));
            amp = AMP_W'(CENTRE + cur_zoff + int'($urandom_range(0, 3)));
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                pc = PHASE_W'($urandom_range(0, span));
            end else if (pick == 5) begin
                case ($urandom_range(0, 3))
                    0: pc = '0;
                    1: pc = PHASE_W'(PHASE_COUNT_MAX);
                    2: pc = PHASE_W'(span);
                    default: pc = PHASE_W'(span + 1);
                endcase
            end else begin
                pc = PHASE_W'($urandom_range(0, PHASE_COUNT_MAX));
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                a = CENTRE + cur_zoff + int'($urandom_range(0, 2400)) - 1200;
                if (a < 0) a = 0;
                if (a > 65535) a = 65535;
                amp = AMP_W'(a);
            end else if (pick == 5) begin
                case ($urandom_range(0, 3))
                    0: amp = '0;
                    1: amp = '1;
                    2: amp = AMP_W'(CENTRE);
                    default: amp = AMP_W'(CENTRE - 1);
                endcase
            end else begin
                amp = AMP_W'($urandom_range(0, 65535));
            end
        end
        send_pulse(op, pc, amp);
    endtask

    // Result side: stall a random number of cycles before each item
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [SCALE_W-1:0] scales [N_SETTINGS];
        int                 zoffs  [N_SETTINGS];
        logic [MODE_W-1:0]  modes  [N_SETTINGS];
        scales = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd1, 24'd65536, 24'h008000,
                   24'd0, 24'h000100};
        zoffs  = '{0, -32768, 32767, 0, 0, -200, 0, 100};
        modes  = '{MODE_50HZ, MODE_60HZ, MODE_RAW, MODE_SPARE, MODE_RAW, MODE_60HZ,
                   MODE_50HZ, MODE_50HZ};
        // One fully random setting
        scales[6] = SCALE_W'($urandom_range(0, 24'hFFFFFF));
        zoffs[6]  = int'($urandom_range(0, 65535)) - 32768;
        modes[6]  = MODE_W'($urandom_range(0, 3));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_setting(scales[s], zoffs[s], modes[s]);
            if (s == 0) begin
                // Centre, repeated hits, full-scale and sign cases
                send_pulse(OP_RECORD, '0, AMP_W'(CENTRE));
                send_pulse(OP_RECORD, '0, AMP_W'(CENTRE));
                send_pulse(OP_RECORD, PHASE_W'(PHASE_COUNT_MAX), '1);
                send_pulse(OP_RECORD, '0, '0);
                send_pulse(OP_RECORD, PHASE_W'(1), AMP_W'(CENTRE + 1));
                send_pulse(OP_RECORD, PHASE_W'(5), AMP_W'(CENTRE - 1));
                // Level limit of the map, exactly and just past it
                send_pulse(OP_RECORD, PHASE_W'(1000), AMP_W'(CENTRE + 1000));
                send_pulse(OP_RECORD, PHASE_W'(1000), AMP_W'(CENTRE - 1000));
                send_pulse(OP_RECORD, PHASE_W'(1000), AMP_W'(CENTRE + 1122));
                send_pulse(OP_RECORD, PHASE_W'(1000), AMP_W'(CENTRE + 1123));
                // Last phase bin and the first one beyond it
                send_pulse(OP_RECORD, PHASE_W'(DIV_50 - 1), AMP_W'(CENTRE + 10));
                send_pulse(OP_RECORD, PHASE_W'(DIV_50), AMP_W'(CENTRE + 10));
                // Clear, then hit the same cells again
                send_pulse(OP_CLEAR, PHASE_W'(PHASE_COUNT_MAX), '1);
                send_pulse(OP_RECORD, '0, AMP_W'(CENTRE));
                send_pulse(OP_RECORD, PHASE_W'(DIV_50 - 1), AMP_W'(CENTRE + 10));
            end
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
                random_pulse();
            end
            calm = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results and let the pipeline settle
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("run covered %0d items (%0d clears) under %0d register settings",
                 sent_items, sent_clears, settings_used);
        $display("%0d results checked, %0d of them landed in the map", checked, hits);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- phase_resolved_pulse_histogram_unit.f -----
hdl/prph_pkg.sv
hdl/prph_mac.sv
hdl/prph_dbsearch.sv
hdl/prph_store.sv
hdl/phase_resolved_pulse_histogram_unit.sv
dv/phase_resolved_pulse_histogram_checker.sv
dv/tb_phase_resolved_pulse_histogram_unit.sv
